// ===== rtl/sawbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sawbc_pkg
// shared constants and types of the write-back cache tag store
// ----------------------------------------------------------------------------
package sawbc_pkg;

    localparam int SETS       = 64;
    localparam int WAYS       = 4;
    localparam int LINE_BYTES = 32;
    localparam int ADDR_BITS  = 48;
    localparam int OUT_BITS   = 48;

    localparam int OFS_BITS  = $clog2(LINE_BYTES);
    localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SET_USED  = $clog2(SETS);
    localparam int TAG_W     = ADDR_BITS - OFS_BITS - SET_USED;
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_BITS = WAY_BITS;

    localparam logic [2:0] OP_PROBE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_FILL  = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;

    typedef logic [TAG_W-1:0]     t_tag;
    typedef logic [SET_BITS-1:0]  t_set;
    typedef logic [RANK_BITS-1:0] t_rank;

    // one way of a set as stored in the memory
    typedef struct packed {
        t_tag  tag;
        logic  valid;
        logic  dirty;
        t_rank rank;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    function automatic logic [OUT_BITS-1:0] line_addr(t_tag tag, t_set set);
        logic [ADDR_BITS+OFS_BITS-1:0] a;
        a = '0;
        a[OFS_BITS +: TAG_W + SET_USED] =
            (TAG_W + SET_USED)'({tag, set} >> (SET_BITS - SET_USED));
        if (SET_USED > 0) begin
            a[OFS_BITS +: SET_BITS] = set;
            a[OFS_BITS + SET_USED +: TAG_W] = tag;
        end else begin
            a[OFS_BITS +: TAG_W] = tag;
        end
        return a[OUT_BITS-1:0];
    endfunction

endpackage

// ===== rtl/sawbc_row_ram.sv =====
// ----------------------------------------------------------------------------
// sawbc_row_ram
// one row per set, registered read, one write port
// ----------------------------------------------------------------------------
module sawbc_row_ram (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  sawbc_pkg::t_set      i_rd_set,
    output sawbc_pkg::t_row      o_rd_row,
    input  logic                 i_wr_en,
    input  sawbc_pkg::t_set      i_wr_set,
    input  sawbc_pkg::t_row      i_wr_row
);

    sawbc_pkg::t_row r_mem [sawbc_pkg::SETS];
    sawbc_pkg::t_row r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_set];
        end
    end

    assign o_rd_row = r_rd;

endmodule

// ===== rtl/set_assoc_write_back_cache_tags.sv =====
// ----------------------------------------------------------------------------
// set_assoc_write_back_cache_tags
// tag store of a set-associative write-back cache with true lru replacement
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass writes every set
// before the first beat is taken. An item is then handled in steps: the
// set row is read from the tag memory, looked up and written back, and
// the result is presented; a flush then reports each dirty line to be
// written back as its own result beat. The row memory read, compare and
// write-back, and the result handshake, set the rate.
module set_assoc_write_back_cache_tags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [47:0] i_address,
    input  logic        i_dirty_flag,
    input  logic        i_flush_writes_back,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic        o_writeback_valid,
    output logic        o_writeback_dirty,
    output logic [47:0] o_writeback_address,
    output logic        o_last
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam int WB = sawbc_pkg::WAY_BITS;
    localparam int NW = sawbc_pkg::WAYS;

    logic [2:0]           r_state, n_state;
    sawbc_pkg::t_set      r_clr, n_clr;
    logic [2:0]           r_op;
    sawbc_pkg::t_tag      r_tag;
    sawbc_pkg::t_set      r_set;
    logic                 r_df, r_fwb;
    logic [NW-1:0]        r_fmask, n_fmask;
    sawbc_pkg::t_row      r_frow, n_frow;
    logic                 r_ov, n_ov;
    logic                 r_hit, n_hit, r_wv, n_wv, r_wd, n_wd, r_last, n_last;
    logic [47:0]          r_wa, n_wa;

    logic                 rd_en, wr_en;
    sawbc_pkg::t_set      rd_set, wr_set;
    sawbc_pkg::t_row      rd_row, wr_row, lk_row;
    logic                 accept;
    logic [sawbc_pkg::ADDR_BITS-1:0] addr;

    assign addr = sawbc_pkg::ADDR_BITS'(i_address);

    sawbc_row_ram u_ram (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en),
        .i_rd_set (rd_set),
        .o_rd_row (rd_row),
        .i_wr_en  (wr_en),
        .i_wr_set (wr_set),
        .i_wr_row (wr_row)
    );

    assign o_ready = (r_state == ST_IDLE) && !r_ov;
    assign accept  = i_valid && o_ready;
    assign rd_en   = accept;
    assign rd_set  = sawbc_pkg::t_set'(addr >> sawbc_pkg::OFS_BITS)
                     & sawbc_pkg::t_set'(sawbc_pkg::SETS - 1);

    // lookup and row update
    always_comb begin
        logic           hit, found;
        logic [WB-1:0]  way, vic, inv;
        sawbc_pkg::t_rank old;
        lk_row = rd_row;
        hit = 1'b0; way = '0; found = 1'b0; inv = '0; vic = '0;
        for (int w = NW - 1; w >= 0; w--) begin
            if (rd_row[w].valid && rd_row[w].tag == r_tag) begin
                hit = 1'b1; way = WB'(w);
            end
            if (!rd_row[w].valid) begin
                found = 1'b1; inv = WB'(w);
            end
            if (rd_row[w].rank == sawbc_pkg::t_rank'(NW - 1) && vic == '0) begin
                vic = WB'(w);
            end
        end
        for (int w = 0; w < NW; w++) begin
            if (rd_row[w].rank == sawbc_pkg::t_rank'(NW - 1)) vic = WB'(w);
        end
        n_hit = hit; n_wv = 1'b0; n_wd = 1'b0; n_wa = '0;
        if (!hit) way = found ? inv : vic;
        old = rd_row[way].rank;
        if (r_op == sawbc_pkg::OP_WRITE || r_op == sawbc_pkg::OP_FILL) begin
            if (hit) begin
                lk_row[way].dirty = (r_op == sawbc_pkg::OP_WRITE) ? 1'b1
                                    : (rd_row[way].dirty | r_df);
            end else begin
                n_wv = rd_row[way].valid;
                n_wd = rd_row[way].valid & rd_row[way].dirty;
                n_wa = rd_row[way].valid
                       ? sawbc_pkg::line_addr(rd_row[way].tag, r_set) : '0;
                lk_row[way].tag   = r_tag;
                lk_row[way].valid = 1'b1;
                lk_row[way].dirty = r_df;
            end
        end
        if ((r_op == sawbc_pkg::OP_READ && hit) || r_op == sawbc_pkg::OP_WRITE
                || r_op == sawbc_pkg::OP_FILL) begin
            for (int w = 0; w < NW; w++) begin
                if (rd_row[w].rank < old) lk_row[w].rank = rd_row[w].rank + 1'b1;
            end
            lk_row[way].rank = '0;
        end
        if (r_op == sawbc_pkg::OP_PROBE) begin
            lk_row = rd_row;
        end
        if (r_op > sawbc_pkg::OP_FLUSH) n_hit = 1'b0;
    end

    always_comb begin
        logic [WB-1:0] fw;
        logic [NW-1:0] rest;
        n_state = r_state; n_clr = r_clr; n_fmask = r_fmask; n_frow = r_frow;
        n_ov = r_ov && !i_ready;
        n_last = r_last;
        wr_en = 1'b0; wr_set = r_set; wr_row = lk_row;
        fw = '0;
        for (int w = NW - 1; w >= 0; w--) if (r_fmask[w]) fw = WB'(w);
        rest = r_fmask & ~(NW'(1) << fw);
        case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1; wr_set = r_clr;
                for (int w = 0; w < NW; w++) begin
                    wr_row[w] = '0;
                    wr_row[w].rank = sawbc_pkg::t_rank'(w);
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == sawbc_pkg::t_set'(sawbc_pkg::SETS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                if (r_op == sawbc_pkg::OP_FLUSH) begin
                    wr_en = 1'b1;
                    for (int w = 0; w < NW; w++) begin
                        wr_row[w].valid = 1'b0;
                        wr_row[w].dirty = 1'b0;
                        n_fmask[w] = rd_row[w].valid & rd_row[w].dirty & r_fwb;
                    end
                    n_frow = rd_row;
                    n_state = ST_FLUSH;
                end else begin
                    wr_en = (r_op <= sawbc_pkg::OP_FLUSH);
                    n_ov = 1'b1; n_last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1;
                    n_last = (rest == '0);
                    n_fmask = rest;
                    if (rest == '0) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic [WB-1:0] fw;
        fw = '0;
        for (int w = NW - 1; w >= 0; w--) if (r_fmask[w]) fw = WB'(w);
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
        r_fmask <= n_fmask;
        r_frow  <= n_frow;
        r_last  <= n_last;
        if (accept) begin
            r_op  <= i_operation;
            r_tag <= sawbc_pkg::t_tag'(addr >> (sawbc_pkg::OFS_BITS + sawbc_pkg::SET_USED));
            r_set <= rd_set;
            r_df  <= i_dirty_flag;
            r_fwb <= i_flush_writes_back;
        end
        if (r_state == ST_LOOK && r_op != sawbc_pkg::OP_FLUSH) begin
            r_hit <= n_hit; r_wv <= n_wv; r_wd <= n_wd; r_wa <= n_wa;
        end else if (r_state == ST_FLUSH && (!r_ov || i_ready)) begin
            r_hit <= 1'b0;
            r_wv  <= r_fmask != '0;
            r_wd  <= r_fmask != '0;
            r_wa  <= (r_fmask != '0) ? sawbc_pkg::line_addr(r_frow[fw].tag, r_set) : '0;
        end
    end

    assign o_valid             = r_ov;
    assign o_hit               = r_hit;
    assign o_writeback_valid   = r_wv;
    assign o_writeback_dirty   = r_wd;
    assign o_writeback_address = r_wa;
    assign o_last              = r_last;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("accept while busy");
    a_wb_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_writeback_dirty) |-> o_writeback_valid) else $error("dirty without wb");
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> !o_writeback_valid) else $error("hit with wb");
`endif

endmodule

// ===== tb/sv/set_assoc_write_back_cache_tags_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_write_back_cache_tags_tb
// drives access and flush beats into the cache tag store, predicts hit, victim
// and flush write-back results with its own lru model and checks every result
// ----------------------------------------------------------------------------
module set_assoc_write_back_cache_tags_tb;

    localparam int NLINES = sawbc_pkg::SETS * sawbc_pkg::WAYS;

    typedef struct {
        logic [2:0]  op;
        logic [47:0] addr;
        logic        dflag;
        logic        fwb;
    } t_access;

    typedef struct {
        logic        hit;
        logic        wb_valid;
        logic        wb_dirty;
        logic [47:0] wb_addr;
        logic        last;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic [47:0] i_address;
    logic        i_dirty_flag;
    logic        i_flush_writes_back;
    logic        o_valid;
    logic        i_ready;
    logic        o_hit;
    logic        o_writeback_valid;
    logic        o_writeback_dirty;
    logic [47:0] o_writeback_address;
    logic        o_last;

    set_assoc_write_back_cache_tags dut (.*);

    t_access  access_q[$];
    t_outcome outcome_q[$];
    int       errors = 0;
    int       send_gap = 0;
    int       recv_gap = 0;
    bit       hold_off = 0;
    bit       stim_done = 0;

    logic [47:0] mdl_tag [NLINES];
    bit          mdl_valid [NLINES];
    bit          mdl_dirty [NLINES];
    int          mdl_rank [NLINES];

    // addresses built from a small pool of tags so hits and evictions happen
    logic [47:0] tag_pool [8];

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [47:0] lru_line_addr(logic [47:0] tag, int set);
        return 48'((tag * sawbc_pkg::SETS + set) * sawbc_pkg::LINE_BYTES);
    endfunction

    task automatic lru_touch(int base, int way);
        int old;
        old = mdl_rank[base + way];
        for (int w = 0; w < sawbc_pkg::WAYS; w++)
            if (mdl_rank[base + w] < old) mdl_rank[base + w]++;
        mdl_rank[base + way] = 0;
    endtask

    task automatic predict_lookup(t_access a);
        logic [47:0] line, tag;
        int set, base, way, hit, found;
        t_outcome o;
        line = a.addr / sawbc_pkg::LINE_BYTES;
        set = int'(line % sawbc_pkg::SETS);
        tag = line / sawbc_pkg::SETS;
        base = set * sawbc_pkg::WAYS;
        o = '{0, 0, 0, 48'd0, 1};
        if (a.op > sawbc_pkg::OP_FLUSH) begin
            outcome_q.push_back(o);
            return;
        end
        if (a.op == sawbc_pkg::OP_FLUSH) begin
            int n;
            n = 0;
            for (int w = 0; w < sawbc_pkg::WAYS; w++) begin
                if (mdl_valid[base + w] && mdl_dirty[base + w] && a.fwb) begin
                    o = '{0, 1, 1, lru_line_addr(mdl_tag[base + w], set), 0};
                    outcome_q.push_back(o);
                    n++;
                end
                mdl_valid[base + w] = 0;
                mdl_dirty[base + w] = 0;
            end
            if (n == 0) outcome_q.push_back('{0, 0, 0, 48'd0, 1});
            else outcome_q[$].last = 1;
            return;
        end
        hit = 0;
        way = 0;
        for (int w = 0; w < sawbc_pkg::WAYS; w++)
            if (hit == 0 && mdl_valid[base + w] && mdl_tag[base + w] == tag) begin
                hit = 1;
                way = w;
            end
        if (a.op == sawbc_pkg::OP_PROBE || a.op == sawbc_pkg::OP_READ) begin
            if (hit != 0 && a.op == sawbc_pkg::OP_READ) lru_touch(base, way);
            o.hit = 1'(hit);
        end else if (hit != 0) begin
            if (a.op == sawbc_pkg::OP_WRITE) mdl_dirty[base + way] = 1;
            else mdl_dirty[base + way] |= a.dflag;
            lru_touch(base, way);
            o.hit = 1;
        end else begin
            found = 0;
            for (int w = 0; w < sawbc_pkg::WAYS; w++)
                if (found == 0 && !mdl_valid[base + w]) begin
                    found = 1;
                    way = w;
                end
            if (found == 0)
                for (int w = 0; w < sawbc_pkg::WAYS; w++)
                    if (mdl_rank[base + w] == sawbc_pkg::WAYS - 1) way = w;
            if (mdl_valid[base + way]) begin
                o.wb_valid = 1;
                o.wb_dirty = mdl_dirty[base + way];
                o.wb_addr = lru_line_addr(mdl_tag[base + way], set);
            end
            mdl_tag[base + way] = tag;
            mdl_valid[base + way] = 1;
            mdl_dirty[base + way] = a.dflag;
            lru_touch(base, way);
        end
        outcome_q.push_back(o);
    endtask

    function automatic t_access rand_access(int mode);
        t_access a;
        int set;
        a.dflag = 1'($urandom_range(0, 1));
        a.fwb = ($urandom_range(0, 3) != 0);
        if (mode == 0) begin
            a.op = 3'($urandom_range(0, 7));
            a.addr = 48'({$urandom, $urandom});
        end else begin
            int r;
            r = $urandom_range(0, 99);
            a.op = r < 15 ? sawbc_pkg::OP_PROBE : r < 35 ? sawbc_pkg::OP_READ :
                   r < 60 ? sawbc_pkg::OP_WRITE : r < 85 ? sawbc_pkg::OP_FILL :
                   r < 95 ? sawbc_pkg::OP_FLUSH : 3'($urandom_range(5, 7));
            set = $urandom_range(0, 3);
            a.addr = lru_line_addr(tag_pool[$urandom_range(0, 7)], set)
                     | 48'($urandom_range(0, sawbc_pkg::LINE_BYTES - 1));
        end
        return a;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            i_operation <= sawbc_pkg::OP_PROBE;
            i_address <= '0;
            i_dirty_flag <= 0;
            i_flush_writes_back <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) predict_lookup('{i_operation, i_address, i_dirty_flag,
                                          i_flush_writes_back});
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 0;
            end else if (access_q.size() > 0) begin
                t_access a;
                a = access_q.pop_front();
                i_valid <= 1;
                i_operation <= a.op;
                i_address <= a.addr;
                i_dirty_flag <= a.dflag;
                i_flush_writes_back <= a.fwb;
                send_gap <= pick_gap();
            end else begin
                i_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    t_outcome e;
                    e = outcome_q.pop_front();
                    if (o_hit !== e.hit) begin
                        $error("hit exp %0h got %0h", e.hit, o_hit); errors++;
                    end
                    if (o_writeback_valid !== e.wb_valid) begin
                        $error("writeback_valid exp %0h got %0h", e.wb_valid,
                               o_writeback_valid); errors++;
                    end
                    if (o_writeback_dirty !== e.wb_dirty) begin
                        $error("writeback_dirty exp %0h got %0h", e.wb_dirty,
                               o_writeback_dirty); errors++;
                    end
                    if (o_writeback_address !== e.wb_addr) begin
                        $error("writeback_address exp %0h got %0h", e.wb_addr,
                               o_writeback_address); errors++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %0h got %0h", e.last, o_last); errors++;
                    end
                end
            end
            if (hold_off) begin
                i_ready <= 0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 0;
            end else begin
                i_ready <= 1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
            end
        end
    end

    initial begin
        t_access a;
        i_rst_n = 0;
        for (int i = 0; i < NLINES; i++) begin
            mdl_valid[i] = 0;
            mdl_dirty[i] = 0;
            mdl_tag[i] = '0;
            mdl_rank[i] = i % sawbc_pkg::WAYS;
        end
        for (int i = 0; i < 8; i++) tag_pool[i] = 48'({$urandom, $urandom} >> 11);
        tag_pool[0] = '0;
        tag_pool[1] = {48{1'b1}} >> 11;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, all ops, eviction of clean and dirty, flush
        access_q.push_back('{sawbc_pkg::OP_PROBE, 48'h0, 0, 0});
        access_q.push_back('{sawbc_pkg::OP_WRITE, 48'hffff_ffff_ffff, 1, 1});
        access_q.push_back('{sawbc_pkg::OP_READ, 48'hffff_ffff_ffe0, 0, 0});
        access_q.push_back('{sawbc_pkg::OP_PROBE, 48'hffff_ffff_ffff, 0, 0});
        for (int w = 0; w < sawbc_pkg::WAYS + 1; w++)
            access_q.push_back('{sawbc_pkg::OP_FILL, lru_line_addr(48'(w + 1), 5),
                                 1'(w % 2), 0});
        access_q.push_back('{sawbc_pkg::OP_FILL, lru_line_addr(48'd3, 5), 1, 0});
        access_q.push_back('{sawbc_pkg::OP_WRITE, lru_line_addr(48'd9, 5), 0, 0});
        access_q.push_back('{sawbc_pkg::OP_WRITE, lru_line_addr(48'd9, 5), 0, 0});
        access_q.push_back('{sawbc_pkg::OP_FLUSH, lru_line_addr(48'd0, 5), 0, 1});
        access_q.push_back('{sawbc_pkg::OP_FLUSH, 48'h0, 0, 1});
        access_q.push_back('{sawbc_pkg::OP_FLUSH, 48'hffff_ffff_ffff, 0, 1});
        for (int w = 0; w < sawbc_pkg::WAYS; w++)
            access_q.push_back('{sawbc_pkg::OP_WRITE, lru_line_addr(48'(w + 7), 9), 1, 0});
        access_q.push_back('{sawbc_pkg::OP_FLUSH, lru_line_addr(48'd0, 9), 0, 0});
        access_q.push_back('{3'd5, 48'h1234, 1, 1});
        access_q.push_back('{3'd7, 48'hffff_ffff_ffff, 1, 1});
        while (access_q.size() > 0) @(posedge i_clk);

        // sender pause until drained
        while (outcome_q.size() > 0 || i_valid) @(posedge i_clk);

        // long receiver hold-off while the sender keeps offering
        hold_off <= 1;
        for (int i = 0; i < 20; i++) access_q.push_back(rand_access(1));
        repeat (200) @(posedge i_clk);
        hold_off <= 0;

        for (int i = 0; i < 480; i++) begin
            a = rand_access($urandom_range(0, 9) == 0 ? 0 : 1);
            access_q.push_back(a);
        end
        while (access_q.size() > 0 || i_valid) @(posedge i_clk);
        while (outcome_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        stim_done = 1;
        if (errors == 0)
            $display("set_assoc_write_back_cache_tags_tb passed");
        else
            $display("set_assoc_write_back_cache_tags_tb failed");
        $finish;
    end

    initial begin
        #2000000;
        if (!stim_done) begin
            $display("set_assoc_write_back_cache_tags_tb failed");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/sawbc_pkg.sv
rtl/sawbc_row_ram.sv
rtl/set_assoc_write_back_cache_tags.sv
tb/sv/set_assoc_write_back_cache_tags_tb.sv
